### src/rpr_pkg.sv
`default_nettype none

package rpr_pkg;

	localparam int POS_FRAC_BITS = 16;
	localparam int PIX_FRAC_BITS = 8;

	// Depth threshold in position units, rounded to nearest.
	localparam logic [10:0] DEPTH_MIN = 11'(((64'd1 << POS_FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic [23:0] PENALTY = 24'(64'd1111 << PIX_FRAC_BITS);

	localparam int Q_BITS = 27;
	localparam logic [Q_BITS-1:0] OFFSET_CAP = Q_BITS'(1) << (Q_BITS - 1);

	typedef enum logic [7:0] {
		REG_FOCAL_X    = 8'd0,
		REG_FOCAL_Y    = 8'd1,
		REG_CENTER_COL = 8'd2,
		REG_CENTER_ROW = 8'd3
	} cfg_reg_e;

	typedef struct packed {
		logic        [23:0] meas_col;
		logic        [23:0] meas_row;
		logic signed [31:0] cam_pos_x;
		logic signed [31:0] cam_pos_y;
		logic signed [31:0] cam_pos_z;
		logic signed [15:0] rot_w;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic signed [31:0] landmark_x;
		logic signed [31:0] landmark_y;
		logic signed [31:0] landmark_z;
	} obs_t;

	typedef struct packed {
		logic signed [23:0] err_col;
		logic signed [23:0] err_row;
		logic               behind_flag;
	} res_t;

	// One axis inside the long divider.
	typedef struct packed {
		logic [61:0]       rem;
		logic [Q_BITS-1:0] low;
		logic [Q_BITS-1:0] quo;
		logic              ovf;
		logic              neg;
	} axis_t;

endpackage

`default_nettype wire

### src/pinhole_reprojection_residual_core.sv
// Pinhole reprojection residual, fully pipelined.
// Input channel obs_valid/obs_stall/obs carries one observation with its
// camera pose and world landmark per beat. Output channel
// res_valid/res_stall/res returns the column and row residuals and the
// behind flag, one result beat per input beat, in order.
// The configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// focal lengths and principal point; it is always ready and should only be
// used while no beat is in flight.
// One beat is taken every cycle while the pipeline is not frozen. Most of
// the pipeline is the one-bit-per-stage divider (27 stages) that forms
// focal * X / Z for both axes side by side.
// The whole pipeline advances together; it freezes only while a result is
// held at the output and res_stall is high, and obs_stall is raised for
// exactly those cycles. Reset clears all valid bits and loads the default
// intrinsics (focal 500, center 320 x 240 pixels).
`default_nettype none

module pinhole_reprojection_residual_core
	import rpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        obs_valid,
	output logic             obs_stall,
	input  wire obs_t        obs,
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_t             res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	logic [23:0] focal_x_q, focal_y_q, center_col_q, center_row_q;
	logic        en;

	assign cfg_ready = 1'b1;
	assign en        = !(res_valid && res_stall);
	assign obs_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q    <= 24'd128000;
			focal_y_q    <= 24'd128000;
			center_col_q <= 24'd81920;
			center_row_q <= 24'd61440;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_FOCAL_X:    focal_x_q    <= cfg_data;
				REG_FOCAL_Y:    focal_y_q    <= cfg_data;
				REG_CENTER_COL: center_col_q <= cfg_data;
				REG_CENTER_ROW: center_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits.
	logic [6:1]      vld_s;
	logic [Q_BITS:0] div_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			div_vld_s <= '0;
			res_valid <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[5:1], obs_valid};
			div_vld_s <= {div_vld_s[Q_BITS-1:0], vld_s[6]};
			res_valid <= div_vld_s[Q_BITS];
		end
	end

	// Stage 1: position difference and quaternion products.
	logic signed [32:0] d_s1 [3];
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic        [23:0] mc_s1, mr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'(obs.landmark_x) - 33'(obs.cam_pos_x);
			d_s1[1] <= 33'(obs.landmark_y) - 33'(obs.cam_pos_y);
			d_s1[2] <= 33'(obs.landmark_z) - 33'(obs.cam_pos_z);
			ww_s1   <= obs.rot_w * obs.rot_w;
			xx_s1   <= obs.rot_x * obs.rot_x;
			yy_s1   <= obs.rot_y * obs.rot_y;
			zz_s1   <= obs.rot_z * obs.rot_z;
			xy_s1   <= obs.rot_x * obs.rot_y;
			wz_s1   <= obs.rot_w * obs.rot_z;
			xz_s1   <= obs.rot_x * obs.rot_z;
			wy_s1   <= obs.rot_w * obs.rot_y;
			yz_s1   <= obs.rot_y * obs.rot_z;
			wx_s1   <= obs.rot_w * obs.rot_x;
			mc_s1   <= obs.meas_col;
			mr_s1   <= obs.meas_row;
		end
	end

	// Stage 2: rotation matrix entries, floored by 16, and squared norm.
	logic signed [33:0] mf [9];
	logic signed [29:0] m_s2 [9];
	logic signed [32:0] d_s2 [3];
	logic        [32:0] n_s2;
	logic        [23:0] mc_s2, mr_s2;

	always_comb begin
		mf[0] = 34'(ww_s1) + 34'(xx_s1) - 34'(yy_s1) - 34'(zz_s1);
		mf[1] = 34'(xy_s1) + 34'(wz_s1) <<< 1;
		mf[2] = 34'(xz_s1) - 34'(wy_s1) <<< 1;
		mf[3] = 34'(xy_s1) - 34'(wz_s1) <<< 1;
		mf[4] = 34'(ww_s1) - 34'(xx_s1) + 34'(yy_s1) - 34'(zz_s1);
		mf[5] = 34'(yz_s1) + 34'(wx_s1) <<< 1;
		mf[6] = 34'(xz_s1) + 34'(wy_s1) <<< 1;
		mf[7] = 34'(yz_s1) - 34'(wx_s1) <<< 1;
		mf[8] = 34'(ww_s1) - 34'(xx_s1) - 34'(yy_s1) + 34'(zz_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				m_s2[k] <= mf[k][33:4];
			end
			d_s2  <= d_s1;
			n_s2  <= 33'(unsigned'(ww_s1)) + 33'(unsigned'(xx_s1))
				+ 33'(unsigned'(yy_s1)) + 33'(unsigned'(zz_s1));
			mc_s2 <= mc_s1;
			mr_s2 <= mr_s1;
		end
	end

	// Stage 3: matrix times difference vector, nine products.
	logic signed [62:0] p_s3 [9];
	logic        [32:0] n_s3;
	logic        [23:0] mc_s3, mr_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				p_s3[k] <= 63'(m_s2[k]) * 63'(d_s2[k % 3]);
			end
			n_s3  <= n_s2;
			mc_s3 <= mc_s2;
			mr_s3 <= mr_s2;
		end
	end

	// Stage 4: row sums, depth test, magnitudes.
	logic signed [63:0] px, py, pz;
	logic        [43:0] lim_full;
	logic        [61:0] magx_s4, magy_s4, den_s4;
	logic               negx_s4, negy_s4, behind_s4;
	logic        [23:0] mc_s4, mr_s4;

	always_comb begin
		px       = 64'(p_s3[0]) + 64'(p_s3[1]) + 64'(p_s3[2]);
		py       = 64'(p_s3[3]) + 64'(p_s3[4]) + 64'(p_s3[5]);
		pz       = 64'(p_s3[6]) + 64'(p_s3[7]) + 64'(p_s3[8]);
		lim_full = 44'(n_s3) * 44'(DEPTH_MIN);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s4   <= px[63];
			negy_s4   <= py[63];
			magx_s4   <= px[63] ? 62'(-px) : px[61:0];
			magy_s4   <= py[63] ? 62'(-py) : py[61:0];
			den_s4    <= pz[61:0];
			behind_s4 <= pz <= $signed({24'd0, lim_full[43:4]});
			mc_s4     <= mc_s3;
			mr_s4     <= mr_s3;
		end
	end

	// Stage 5: partial products of magnitude and focal length.
	logic [54:0] lox_s5, hix_s5, loy_s5, hiy_s5;
	logic [61:0] den_s5;
	logic        negx_s5, negy_s5, behind_s5;
	logic [23:0] mc_s5, mr_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			lox_s5    <= 55'(magx_s4[30:0]) * 55'(focal_x_q);
			hix_s5    <= 55'(magx_s4[61:31]) * 55'(focal_x_q);
			loy_s5    <= 55'(magy_s4[30:0]) * 55'(focal_y_q);
			hiy_s5    <= 55'(magy_s4[61:31]) * 55'(focal_y_q);
			den_s5    <= den_s4;
			negx_s5   <= negx_s4;
			negy_s5   <= negy_s4;
			behind_s5 <= behind_s4;
			mc_s5     <= mc_s4;
			mr_s5     <= mr_s4;
		end
	end

	// Stage 6: full dividends.
	logic [85:0] numx_s6, numy_s6;
	logic [61:0] den_s6;
	logic        negx_s6, negy_s6, behind_s6;
	logic [23:0] mc_s6, mr_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s6   <= (86'(hix_s5) << 31) + 86'(lox_s5);
			numy_s6   <= (86'(hiy_s5) << 31) + 86'(loy_s5);
			den_s6    <= den_s5;
			negx_s6   <= negx_s5;
			negy_s6   <= negy_s5;
			behind_s6 <= behind_s5;
			mc_s6     <= mc_s5;
			mr_s6     <= mr_s5;
		end
	end

	// Divider: index 0 holds the overflow check, then one quotient bit per stage.
	axis_t       divx_s [Q_BITS+1];
	axis_t       divy_s [Q_BITS+1];
	logic [61:0] den_s  [Q_BITS+1];
	logic        behind_s [Q_BITS+1];
	logic [23:0] mc_s [Q_BITS+1];
	logic [23:0] mr_s [Q_BITS+1];

	function automatic axis_t div_step(axis_t a, logic [61:0] den);
		logic [62:0] trial;
		axis_t       r;
		trial = {a.rem, a.low[Q_BITS-1]};
		r     = a;
		r.low = a.low << 1;
		if (trial >= {1'b0, den}) begin
			r.rem = 62'(trial - {1'b0, den});
			r.quo = {a.quo[Q_BITS-2:0], 1'b1};
		end else begin
			r.rem = trial[61:0];
			r.quo = {a.quo[Q_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			divx_s[0].rem <= 62'(numx_s6[85:Q_BITS]);
			divx_s[0].low <= numx_s6[Q_BITS-1:0];
			divx_s[0].quo <= '0;
			divx_s[0].ovf <= 62'(numx_s6[85:Q_BITS]) >= den_s6;
			divx_s[0].neg <= negx_s6;
			divy_s[0].rem <= 62'(numy_s6[85:Q_BITS]);
			divy_s[0].low <= numy_s6[Q_BITS-1:0];
			divy_s[0].quo <= '0;
			divy_s[0].ovf <= 62'(numy_s6[85:Q_BITS]) >= den_s6;
			divy_s[0].neg <= negy_s6;
			den_s[0]      <= den_s6;
			behind_s[0]   <= behind_s6;
			mc_s[0]       <= mc_s6;
			mr_s[0]       <= mr_s6;
			for (int k = 1; k <= Q_BITS; k++) begin
				divx_s[k]   <= div_step(divx_s[k-1], den_s[k-1]);
				divy_s[k]   <= div_step(divy_s[k-1], den_s[k-1]);
				den_s[k]    <= den_s[k-1];
				behind_s[k] <= behind_s[k-1];
				mc_s[k]     <= mc_s[k-1];
				mr_s[k]     <= mr_s[k-1];
			end
		end
	end

	// Final stage: cap, sign, subtract and saturate.
	function automatic logic [23:0] resid(axis_t a, logic [23:0] meas, logic [23:0] center);
		logic        [Q_BITS-1:0] off;
		logic signed [28:0]       soff;
		logic signed [28:0]       e;
		off  = (a.ovf || a.quo > OFFSET_CAP) ? OFFSET_CAP : a.quo;
		soff = a.neg ? -$signed({2'b00, off}) : $signed({2'b00, off});
		e    = $signed({5'd0, meas}) - $signed({5'd0, center}) - soff;
		if (e[28:23] == {6{e[28]}}) begin
			return e[23:0];
		end
		return e[28] ? 24'h800000 : 24'h7FFFFF;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			if (behind_s[Q_BITS]) begin
				res.err_col <= PENALTY;
				res.err_row <= PENALTY;
			end else begin
				res.err_col <= resid(divx_s[Q_BITS], mc_s[Q_BITS], center_col_q);
				res.err_row <= resid(divy_s[Q_BITS], mr_s[Q_BITS], center_row_q);
			end
			res.behind_flag <= behind_s[Q_BITS];
		end
	end

	a_penalty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.behind_flag |-> res.err_col == PENALTY && res.err_row == PENALTY)
		else $error("penalty result carries wrong residuals");

	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4] && !behind_s4 |-> den_s4 != '0)
		else $error("projected item with zero depth");

	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[Q_BITS] && !behind_s[Q_BITS] && !divx_s[Q_BITS].ovf
		|-> divx_s[Q_BITS].rem < den_s[Q_BITS])
		else $error("column remainder not below divisor");

	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[Q_BITS] && !behind_s[Q_BITS] && !divy_s[Q_BITS].ovf
		|-> divy_s[Q_BITS].rem < den_s[Q_BITS])
		else $error("row remainder not below divisor");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench
	import rpr_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] REG_UNUSED = 8'd9;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	class residual_scoreboard;
		res_t pending[$];
		logic [23:0] focal_x;
		logic [23:0] focal_y;
		logic [23:0] ctr_col;
		logic [23:0] ctr_row;
		int errors;

		function new();
			focal_x = 24'd128000;
			focal_y = 24'd128000;
			ctr_col = 24'd81920;
			ctr_row = 24'd61440;
			errors = 0;
		endfunction

		function void set_reg(logic [7:0] idx, logic [23:0] data);
			if (idx == REG_FOCAL_X) focal_x = data;
			else if (idx == REG_FOCAL_Y) focal_y = data;
			else if (idx == REG_CENTER_COL) ctr_col = data;
			else if (idx == REG_CENTER_ROW) ctr_row = data;
		endfunction

		function logic [23:0] pixel_error(logic [23:0] meas, logic [23:0] center,
				logic [23:0] focal, logic signed [127:0] num, logic signed [127:0] den);
			logic signed [127:0] mag;
			logic signed [127:0] off;
			logic signed [127:0] e;
			mag = (num < 0) ? -num : num;
			off = (mag * $signed({1'b0, focal})) / den;
			if (off > (128'sd1 <<< 26)) off = 128'sd1 <<< 26;
			if (num < 0) off = -off;
			e = $signed({1'b0, meas}) - $signed({1'b0, center}) - off;
			if (e > 128'sd8388607) e = 128'sd8388607;
			if (e < -128'sd8388608) e = -128'sd8388608;
			return e[23:0];
		endfunction

		function void note_obs(obs_t o);
			logic signed [127:0] d0, d1, d2, w, x, y, z, ww, xx, yy, zz, n, lim;
			logic signed [127:0] px, py, pz;
			logic signed [127:0] m[9];
			res_t r;
			d0 = $signed(o.landmark_x) - $signed(o.cam_pos_x);
			d1 = $signed(o.landmark_y) - $signed(o.cam_pos_y);
			d2 = $signed(o.landmark_z) - $signed(o.cam_pos_z);
			w = $signed(o.rot_w);
			x = $signed(o.rot_x);
			y = $signed(o.rot_y);
			z = $signed(o.rot_z);
			ww = w * w;
			xx = x * x;
			yy = y * y;
			zz = z * z;
			m[0] = ww + xx - yy - zz;
			m[1] = 2 * (x * y + w * z);
			m[2] = 2 * (x * z - w * y);
			m[3] = 2 * (x * y - w * z);
			m[4] = ww - xx + yy - zz;
			m[5] = 2 * (y * z + w * x);
			m[6] = 2 * (x * z + w * y);
			m[7] = 2 * (y * z - w * x);
			m[8] = ww - xx - yy + zz;
			for (int k = 0; k < 9; k++) m[k] = m[k] >>> 4;
			px = m[0] * d0 + m[1] * d1 + m[2] * d2;
			py = m[3] * d0 + m[4] * d1 + m[5] * d2;
			pz = m[6] * d0 + m[7] * d1 + m[8] * d2;
			n = ww + xx + yy + zz;
			lim = ($signed({1'b0, DEPTH_MIN}) * n) / 16;
			if (pz <= 0 || pz <= lim) begin
				r.err_col = PENALTY;
				r.err_row = PENALTY;
				r.behind_flag = 1'b1;
			end else begin
				r.err_col = pixel_error(o.meas_col, ctr_col, focal_x, px, pz);
				r.err_row = pixel_error(o.meas_row, ctr_row, focal_y, py, pz);
				r.behind_flag = 1'b0;
			end
			pending = {pending, r};
		endfunction

		function void check_res(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.err_col !== want.err_col) begin
				$display("%0t: err_col expected %0d actual %0d", $time,
					want.err_col, got.err_col);
				errors++;
			end
			if (got.err_row !== want.err_row) begin
				$display("%0t: err_row expected %0d actual %0d", $time,
					want.err_row, got.err_row);
				errors++;
			end
			if (got.behind_flag !== want.behind_flag) begin
				$display("%0t: behind_flag expected %0b actual %0b", $time,
					want.behind_flag, got.behind_flag);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic obs_valid = 1'b0;
	logic obs_stall;
	obs_t obs = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	residual_scoreboard sb = new();
	int cycles = 0;
	int hold_left = 0;
	bit calm = 1'b0;

	pinhole_reprojection_residual_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.obs_valid(obs_valid),
		.obs_stall(obs_stall),
		.obs(obs),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) sb.check_res(res);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !calm && ($urandom_range(99) < 18);
			end
		end
	end

	task automatic send_obs(obs_t o);
		int gap;
		obs <= o;
		obs_valid <= 1'b1;
		do @(posedge clk); while (obs_stall);
		sb.note_obs(o);
		gap = (!calm && $urandom_range(99) < 18) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			obs_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		obs_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_intrinsics(logic [23:0] fx, logic [23:0] fy,
			logic [23:0] cc, logic [23:0] cr);
		drain();
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_COL, cc);
		write_reg(REG_CENTER_ROW, cr);
	endtask

	function automatic obs_t noise_obs();
		obs_t o;
		o.meas_col = 24'($urandom);
		o.meas_row = 24'($urandom);
		o.cam_pos_x = $urandom;
		o.cam_pos_y = $urandom;
		o.cam_pos_z = $urandom;
		o.rot_w = 16'($urandom);
		o.rot_x = 16'($urandom);
		o.rot_y = 16'($urandom);
		o.rot_z = 16'($urandom);
		o.landmark_x = $urandom;
		o.landmark_y = $urandom;
		o.landmark_z = $urandom;
		return o;
	endfunction

	// A camera looking roughly along +z at a landmark placed 0.5 to 60 units along z.
	function automatic obs_t scene_obs();
		obs_t o;
		int depth;
		o.meas_col = 24'($urandom_range(0, 640 << 8));
		o.meas_row = 24'($urandom_range(0, 480 << 8));
		o.cam_pos_x = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		o.cam_pos_y = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		o.cam_pos_z = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		o.rot_w = 16'($urandom_range(14000, 16384));
		o.rot_x = 16'($signed($urandom_range(0, 6000)) - 3000);
		o.rot_y = 16'($signed($urandom_range(0, 6000)) - 3000);
		o.rot_z = 16'($signed($urandom_range(0, 6000)) - 3000);
		depth = $urandom_range(1 << 15, 60 << 16);
		o.landmark_z = depth;
		o.landmark_x = $signed($urandom_range(0, depth)) - depth / 2;
		o.landmark_y = $signed($urandom_range(0, depth)) - depth / 2;
		return o;
	endfunction

	function automatic obs_t axis_obs(logic signed [15:0] w, logic signed [31:0] lx,
			logic signed [31:0] ly, logic signed [31:0] lz);
		obs_t o;
		o = '0;
		o.meas_col = 24'd81920;
		o.meas_row = 24'd61440;
		o.rot_w = w;
		o.landmark_x = lx;
		o.landmark_y = ly;
		o.landmark_z = lz;
		return o;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75) send_obs(scene_obs());
			else send_obs(noise_obs());
		end
	endtask

	initial begin
		obs_t o;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_obs(axis_obs(16'sd16384, 32'sd65536, -32'sd65536, 32'sd2 << 16));
		send_obs(axis_obs(16'sd0, 32'sd0, 32'sd0, 32'sd65536));
		send_obs(axis_obs(16'sd16384, 32'sd0, 32'sd0, -32'sd65536));
		send_obs(axis_obs(16'sd16384, 32'sd100, 32'sd100, 32'sd7));
		send_obs(axis_obs(16'sd16384, 32'sd100, 32'sd100, 32'sd8));
		send_obs(axis_obs(16'sd1, 32'sd5, 32'sd5, 32'sd1000));
		send_obs(axis_obs(16'sd4, 32'sd5, -32'sd5, 32'sd8));
		send_obs(axis_obs(16'sd4, 32'sd5, -32'sd5, 32'sd7));
		send_obs(axis_obs(16'sd16384, 32'h7fffffff, -32'sh80000000, 32'sd1 << 8));
		send_obs(axis_obs(-16'sd32768, -32'sd5 << 16, 32'sd3 << 16, 32'h7fffffff));
		o = axis_obs(16'sd16384, 32'sd0, 32'sd0, 32'h7fffffff);
		o.cam_pos_z = 32'sh80000000;
		o.meas_col = 24'hffffff;
		o.meas_row = 24'h000000;
		send_obs(o);
		o = '1;
		send_obs(o);
		o = '0;
		o.rot_w = -16'sd32768;
		o.rot_x = -16'sd32768;
		o.rot_y = -16'sd32768;
		o.rot_z = -16'sd32768;
		o.cam_pos_x = 32'sh80000000;
		o.landmark_z = 32'h7fffffff;
		send_obs(o);
		o.rot_w = 16'sh7fff;
		o.rot_x = 16'sh7fff;
		o.rot_y = 16'sh7fff;
		o.rot_z = 16'sh7fff;
		send_obs(o);
		for (int i = 0; i < 6; i++) send_obs(noise_obs());

		set_intrinsics(24'd0, 24'd0, 24'd81920, 24'd61440);
		write_reg(REG_UNUSED, 24'hffffff);
		send_obs(axis_obs(16'sd16384, 32'sd3 << 16, -32'sd2 << 16, 32'sd1 << 16));
		random_phase(150);

		set_intrinsics(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
		random_phase(150);

		set_intrinsics(24'd1, 24'd128000, 24'd0, 24'd0);
		calm = 1'b1;
		random_phase(150);
		calm = 1'b0;

		set_intrinsics(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		hold_left = 400;
		random_phase(200);

		set_intrinsics(24'd128000, 24'd96000, 24'd81920, 24'd61440);
		random_phase(200);

		set_intrinsics(24'($urandom_range(50000, 300000)),
			24'($urandom_range(50000, 300000)),
			24'($urandom_range(0, 200000)), 24'($urandom_range(0, 200000)));
		random_phase(230);

		drain();
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
